/* design/gcab_pkg.sv */
package gcab_pkg;

    localparam int unsigned MAX_DIM   = 4096;
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned POS_W     = 12;
    localparam int unsigned IDX_W     = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_BUFFER_WIDTH  = 3'd2,
        REG_BUFFER_HEIGHT = 3'd3,
        REG_TEXT_COLOR    = 3'd4,
        REG_GRAY_MODE     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [DIM_W-1:0]   buffer_width;
        logic [DIM_W-1:0]   buffer_height;
        logic [31:0]        text_color;
        logic               gray_mode;
    } cfg_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        clamp_dim = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    endfunction

    // exact n/255 for n <= 255*255
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] s;
        s = {1'b0, n} + {9'b0, n[15:8]} + 17'd1;
        div255 = s[15:8];
    endfunction

endpackage

/* design/glyph_coverage_alpha_blend_core.sv */
// Channel | Handshake            | Payload
// input   | in_valid / in_stall  | coverage, glyph_col, glyph_row, dest_pixel
// output  | out_valid / out_stall| write_enable, pixel_index, new_pixel
// config  | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; an accepted transaction
// passes three datapath stages and then the output register, the first stage loading
// at its accepting edge.
// Stages advance together; a stalled output freezes the whole pipeline and
// raises in_stall. Async active-low reset clears valid bits and loads the
// register defaults.
module glyph_coverage_alpha_blend_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        coverage,
    input  logic [7:0]                        glyph_col,
    input  logic [7:0]                        glyph_row,
    input  logic [31:0]                       dest_pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              write_enable,
    output logic [gcab_pkg::IDX_W-1:0]        pixel_index,
    output logic [31:0]                       new_pixel,
    input  logic                              cfg_we,
    input  logic [gcab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gcab_pkg::CFG_W-1:0]        cfg_data
);

    gcab_pkg::cfg_t             cfg_reg;
    logic                       adv;
    logic [2:0]                 valid_reg;
    logic                       out_valid_reg;
    logic                       write_enable_reg;
    logic [gcab_pkg::IDX_W-1:0] pixel_index_reg;
    logic [31:0]                new_pixel_reg;
    logic                       write_enable_next;
    logic                       clip;
    logic                       no_write;
    logic [gcab_pkg::IDX_W-1:0] idx;
    logic [31:0]                pix;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= 16'sd0;
            cfg_reg.origin_y      <= 16'sd0;
            cfg_reg.buffer_width  <= 13'd640;
            cfg_reg.buffer_height <= 13'd480;
            cfg_reg.text_color    <= 32'hFF000000;
            cfg_reg.gray_mode     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (gcab_pkg::reg_index_t'(cfg_index))
                gcab_pkg::REG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data[15:0];
                gcab_pkg::REG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data[15:0];
                gcab_pkg::REG_BUFFER_WIDTH:  cfg_reg.buffer_width  <= cfg_data[12:0];
                gcab_pkg::REG_BUFFER_HEIGHT: cfg_reg.buffer_height <= cfg_data[12:0];
                gcab_pkg::REG_TEXT_COLOR:    cfg_reg.text_color    <= cfg_data;
                gcab_pkg::REG_GRAY_MODE:     cfg_reg.gray_mode     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    gcab_geom u_geom (
        .clk       (clk),
        .en        (adv),
        .cfg       (cfg_reg),
        .glyph_col (glyph_col),
        .glyph_row (glyph_row),
        .clip      (clip),
        .idx       (idx)
    );

    gcab_blend u_blend (
        .clk        (clk),
        .en         (adv),
        .cfg        (cfg_reg),
        .coverage   (coverage),
        .dest_pixel (dest_pixel),
        .no_write   (no_write),
        .pix        (pix)
    );

    assign write_enable_next = valid_reg[2] && !clip && !no_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[1:0], in_valid};
            out_valid_reg <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            write_enable_reg <= write_enable_next;
            pixel_index_reg  <= write_enable_next ? idx : '0;
            new_pixel_reg    <= write_enable_next ? pix : 32'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = write_enable_reg;
    assign pixel_index  = pixel_index_reg;
    assign new_pixel    = new_pixel_reg;

endmodule

/* design/gcab_geom.sv */
module gcab_geom (
    input  logic                           clk,
    input  logic                           en,
    input  gcab_pkg::cfg_t                 cfg,
    input  logic [7:0]                     glyph_col,
    input  logic [7:0]                     glyph_row,
    output logic                           clip,
    output logic [gcab_pkg::IDX_W-1:0]     idx
);

    logic [gcab_pkg::DIM_W-1:0] bw;
    logic [gcab_pkg::DIM_W-1:0] bh;
    logic signed [16:0]         x_next;
    logic signed [16:0]         y_next;
    logic                       clip1_next;

    logic                       clip1_reg;
    logic [gcab_pkg::POS_W-1:0] x1_reg;
    logic [gcab_pkg::POS_W-1:0] y1_reg;
    logic                       clip2_reg;
    logic [gcab_pkg::POS_W-1:0] x2_reg;
    logic [24:0]                ymul2_reg;
    logic                       clip3_reg;
    logic [gcab_pkg::IDX_W-1:0] idx3_reg;

    assign bw = gcab_pkg::clamp_dim(cfg.buffer_width);
    assign bh = gcab_pkg::clamp_dim(cfg.buffer_height);

    always_comb
    begin
        x_next = {cfg.origin_x[15], cfg.origin_x} + $signed({9'b0, glyph_col});
        y_next = {cfg.origin_y[15], cfg.origin_y} + $signed({9'b0, glyph_row});
        clip1_next = x_next[16] || y_next[16]
                  || (x_next[15:0] >= {3'b0, bw})
                  || (y_next[15:0] >= {3'b0, bh});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clip1_reg <= clip1_next;
            x1_reg    <= x_next[gcab_pkg::POS_W-1:0];
            y1_reg    <= y_next[gcab_pkg::POS_W-1:0];
            clip2_reg <= clip1_reg;
            x2_reg    <= x1_reg;
            ymul2_reg <= y1_reg * bw;
            clip3_reg <= clip2_reg;
            idx3_reg  <= ymul2_reg[gcab_pkg::IDX_W-1:0]
                       + {{(gcab_pkg::IDX_W-gcab_pkg::POS_W){1'b0}}, x2_reg};
        end
    end

    assign clip = clip3_reg;
    assign idx  = idx3_reg;

endmodule

/* design/gcab_blend.sv */
module gcab_blend (
    input  logic           clk,
    input  logic           en,
    input  gcab_pkg::cfg_t cfg,
    input  logic [7:0]     coverage,
    input  logic [31:0]    dest_pixel,
    output logic           no_write,
    output logic [31:0]    pix
);

    logic [7:0]  a0, r0, g0, b0;
    logic [7:0]  cov_eff;
    logic [7:0]  inv2;

    logic        covz1_reg;
    logic [15:0] prod1_reg;
    logic [31:0] dest1_reg;
    logic        covz2_reg;
    logic [7:0]  sa2_reg;
    logic [31:0] dest2_reg;
    logic        zero3_reg;
    logic        full3_reg;
    logic [7:0]  sa3_reg;
    logic [15:0] da3_reg, r3_reg, g3_reg, b3_reg;
    logic [7:0]  oa;

    assign a0 = cfg.text_color[31:24];
    assign r0 = cfg.text_color[23:16];
    assign g0 = cfg.text_color[15:8];
    assign b0 = cfg.text_color[7:0];

    // mono mode: any nonzero sample is full coverage
    assign cov_eff = cfg.gray_mode ? coverage : ((coverage != 8'd0) ? 8'hFF : 8'h00);
    assign inv2    = 8'hFF - sa2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            covz1_reg <= (cov_eff == 8'd0);
            prod1_reg <= a0 * cov_eff;
            dest1_reg <= dest_pixel;

            covz2_reg <= covz1_reg;
            sa2_reg   <= gcab_pkg::div255(prod1_reg);
            dest2_reg <= dest1_reg;

            zero3_reg <= covz2_reg || (sa2_reg == 8'd0);
            full3_reg <= (sa2_reg == 8'hFF);
            sa3_reg   <= sa2_reg;
            da3_reg   <= dest2_reg[31:24] * inv2;
            r3_reg    <= sa2_reg * r0 + inv2 * dest2_reg[23:16];
            g3_reg    <= sa2_reg * g0 + inv2 * dest2_reg[15:8];
            b3_reg    <= sa2_reg * b0 + inv2 * dest2_reg[7:0];
        end
    end

    assign oa       = sa3_reg + gcab_pkg::div255(da3_reg);
    assign no_write = zero3_reg;
    assign pix      = full3_reg ? {8'hFF, cfg.text_color[23:0]}
                                : {oa, gcab_pkg::div255(r3_reg),
                                   gcab_pkg::div255(g3_reg), gcab_pkg::div255(b3_reg)};

endmodule

/* design/gcab_checker.sv */
module gcab_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           write_enable,
    input logic [gcab_pkg::IDX_W-1:0]     pixel_index,
    input logic [31:0]                    new_pixel
);

    // input backpressure comes only from a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow output backpressure");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(write_enable)
            && $stable(pixel_index) && $stable(new_pixel))
        else $error("stalled result changed");

    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> pixel_index == '0 && new_pixel == 32'd0)
        else $error("suppressed write carries nonzero fields");

    // blended alpha is at least the nonzero source alpha
    a_alpha_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> new_pixel[31:24] != 8'd0)
        else $error("written pixel has zero alpha");

endmodule

bind glyph_coverage_alpha_blend_core gcab_checker u_gcab_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .pixel_index  (pixel_index),
    .new_pixel    (new_pixel)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF        = 10;
    localparam int PIPE_LAT        = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int MAX_WAIT        = 10;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_PHASE      = 3;

    // indexes with no register behind them
    localparam logic [gcab_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [gcab_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [7:0]  coverage;
        logic [7:0]  glyph_col;
        logic [7:0]  glyph_row;
        logic [31:0] dest_pixel;
    } glyph_px_t;

    typedef struct packed {
        logic                       write_enable;
        logic [gcab_pkg::IDX_W-1:0] pixel_index;
        logic [31:0]                new_pixel;
    } px_write_t;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic [7:0]                     coverage   = '0;
    logic [7:0]                     glyph_col  = '0;
    logic [7:0]                     glyph_row  = '0;
    logic [31:0]                    dest_pixel = '0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic                           write_enable;
    logic [gcab_pkg::IDX_W-1:0]     pixel_index;
    logic [31:0]                    new_pixel;
    logic                           cfg_we     = 1'b0;
    logic [gcab_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [gcab_pkg::CFG_W-1:0]     cfg_data   = '0;

    // register image kept by the bench
    logic signed [15:0]           m_origin_x      = 16'sd0;
    logic signed [15:0]           m_origin_y      = 16'sd0;
    logic [gcab_pkg::DIM_W-1:0]   m_buffer_width  = 13'd640;
    logic [gcab_pkg::DIM_W-1:0]   m_buffer_height = 13'd480;
    logic [31:0]                  m_text_color    = 32'hFF00_0000;
    logic                         m_gray_mode     = 1'b1;

    glyph_px_t px_todo_q[$];
    px_write_t px_write_q[$];

    logic tx_gaps_on   = 1'b0;
    logic rx_stalls_on = 1'b0;
    logic hold_req     = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;
    int   tx_gap       = 0;
    int   rx_stall     = 0;
    int   err_count    = 0;
    int   cycle_count  = 0;

    glyph_coverage_alpha_blend_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coverage     (coverage),
        .glyph_col    (glyph_col),
        .glyph_row    (glyph_row),
        .dest_pixel   (dest_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_enable (write_enable),
        .pixel_index  (pixel_index),
        .new_pixel    (new_pixel),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic px_write_t blend_pixel(input glyph_px_t px);
        px_write_t   res;
        int unsigned cv, bw, bh, a0, sa, inv, oa, rr, gg, bb;
        int          x, y;
        res = '0;
        cv = px.coverage;
        if (!m_gray_mode && cv != 0)
            cv = 255;
        bw = (m_buffer_width > gcab_pkg::MAX_DIM) ? gcab_pkg::MAX_DIM : m_buffer_width;
        bh = (m_buffer_height > gcab_pkg::MAX_DIM) ? gcab_pkg::MAX_DIM : m_buffer_height;
        x = int'(m_origin_x) + int'(px.glyph_col);
        y = int'(m_origin_y) + int'(px.glyph_row);
        a0 = m_text_color[31:24];
        sa = a0 * cv / 255;
        if (cv == 0 || x < 0 || y < 0 || x >= int'(bw) || y >= int'(bh) || sa == 0)
            return res;
        res.write_enable = 1'b1;
        res.pixel_index  = gcab_pkg::IDX_W'(y * int'(bw) + x);
        if (sa >= 255)
        begin
            res.new_pixel = {8'hFF, m_text_color[23:0]};
        end
        else
        begin
            inv = 255 - sa;
            oa = sa + px.dest_pixel[31:24] * inv / 255;
            rr = (sa * m_text_color[23:16] + inv * px.dest_pixel[23:16]) / 255;
            gg = (sa * m_text_color[15:8] + inv * px.dest_pixel[15:8]) / 255;
            bb = (sa * m_text_color[7:0] + inv * px.dest_pixel[7:0]) / 255;
            res.new_pixel = {8'(oa), 8'(rr), 8'(gg), 8'(bb)};
        end
        return res;
    endfunction

    // input side: one transaction per accepted sample
    always @(posedge clk or negedge rst_n)
    begin : tx_drive
        glyph_px_t nxt;
        logic      nv;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                px_write_q = {px_write_q,
                              blend_pixel({coverage, glyph_col, glyph_row, dest_pixel})};
            if (!(in_valid && in_stall))
            begin
                nv = 1'b0;
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                end
                else if (px_todo_q.size() != 0)
                begin
                    nxt = px_todo_q.pop_front();
                    coverage   <= nxt.coverage;
                    glyph_col  <= nxt.glyph_col;
                    glyph_row  <= nxt.glyph_row;
                    dest_pixel <= nxt.dest_pixel;
                    nv = 1'b1;
                    tx_gap <= tx_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
                end
                in_valid <= nv;
            end
        end
    end

    // long receiver hold-off, started by a toggle of hold_req
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // output side: check each result transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : rx_check
        px_write_t want;
        int        sl;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_stall  <= 0;
        end
        else
        begin
            sl = rx_stall;
            if (out_valid && !out_stall)
            begin
                if (px_write_q.size() == 0)
                begin
                    $display("%0t: unexpected result we=%0b idx=%06h pix=%08h",
                             $time, write_enable, pixel_index, new_pixel);
                    err_count++;
                end
                else
                begin
                    want = px_write_q.pop_front();
                    if (write_enable !== want.write_enable)
                    begin
                        $display("%0t: write_enable expected %0b actual %0b",
                                 $time, want.write_enable, write_enable);
                        err_count++;
                    end
                    if (pixel_index !== want.pixel_index)
                    begin
                        $display("%0t: pixel_index expected %06h actual %06h",
                                 $time, want.pixel_index, pixel_index);
                        err_count++;
                    end
                    if (new_pixel !== want.new_pixel)
                    begin
                        $display("%0t: new_pixel expected %08h actual %08h",
                                 $time, want.new_pixel, new_pixel);
                        err_count++;
                    end
                end
                sl = rx_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else if (sl != 0)
            begin
                sl = sl - 1;
            end
            rx_stall  <= sl;
            out_stall <= (sl != 0) || (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic set_reg(input logic [gcab_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcab_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        unique case (idx)
            gcab_pkg::REG_ORIGIN_X:      m_origin_x      = data[15:0];
            gcab_pkg::REG_ORIGIN_Y:      m_origin_y      = data[15:0];
            gcab_pkg::REG_BUFFER_WIDTH:  m_buffer_width  = data[gcab_pkg::DIM_W-1:0];
            gcab_pkg::REG_BUFFER_HEIGHT: m_buffer_height = data[gcab_pkg::DIM_W-1:0];
            gcab_pkg::REG_TEXT_COLOR:    m_text_color    = data;
            gcab_pkg::REG_GRAY_MODE:     m_gray_mode     = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_pace(input logic tx, input logic rx);
        @(posedge clk);
        tx_gaps_on   <= tx;
        rx_stalls_on <= rx;
    endtask

    task automatic queue_px(input logic [7:0] cv, input logic [7:0] col,
                            input logic [7:0] row, input logic [31:0] dst);
        px_todo_q = {px_todo_q, glyph_px_t'({cv, col, row, dst})};
    endtask

    // sampled at the falling edge to stay clear of the driver
    task automatic drain();
        do
            @(negedge clk);
        while (px_todo_q.size() != 0 || in_valid || px_write_q.size() != 0);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    initial
    begin : stim
        int          cv, col, row, pick;
        int unsigned dim;
        logic [31:0] color;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset registers: opaque black, gray coverage, 640x480
        set_pace(1'b1, 1'b1);
        queue_px(8'd0, 8'd7, 8'd7, 32'hFFFF_FFFF);
        queue_px(8'd255, 8'd0, 8'd0, 32'hFFFF_FFFF);
        queue_px(8'd128, 8'd255, 8'd255, 32'hFFFF_FFFF);
        queue_px(8'd1, 8'd10, 8'd3, 32'h0000_0000);
        drain();

        // small clipped window, half alpha
        set_reg(gcab_pkg::REG_ORIGIN_X, 32'h1234_FFFB);
        set_reg(gcab_pkg::REG_ORIGIN_Y, 32'h0000_FFFD);
        set_reg(gcab_pkg::REG_BUFFER_WIDTH, 32'd20);
        set_reg(gcab_pkg::REG_BUFFER_HEIGHT, 32'd10);
        set_reg(gcab_pkg::REG_TEXT_COLOR, 32'h80FF_4020);
        set_reg(gcab_pkg::REG_GRAY_MODE, 32'hFFFF_FFFF);
        queue_px(8'd255, 8'd0, 8'd0, 32'h1234_5678);
        queue_px(8'd255, 8'd5, 8'd3, 32'h1234_5678);
        queue_px(8'd255, 8'd24, 8'd12, 32'h8040_C0FF);
        queue_px(8'd255, 8'd25, 8'd3, 32'h1234_5678);
        queue_px(8'd255, 8'd5, 8'd13, 32'h1234_5678);
        queue_px(8'd1, 8'd6, 8'd4, 32'h1234_5678);   // alpha rounds to zero
        queue_px(8'd2, 8'd6, 8'd4, 32'hFFFF_FFFF);
        drain();

        // mono coverage, opaque color
        set_reg(gcab_pkg::REG_GRAY_MODE, 32'hFFFF_FFFE);
        set_reg(gcab_pkg::REG_TEXT_COLOR, 32'hFF00_FF00);
        queue_px(8'd1, 8'd6, 8'd4, 32'h0000_0000);
        queue_px(8'd0, 8'd6, 8'd4, 32'h0000_0000);
        queue_px(8'd170, 8'd7, 8'd5, 32'hFFFF_FFFF);
        drain();

        // zero width clips everything
        set_reg(gcab_pkg::REG_BUFFER_WIDTH, 32'hFFFF_E000);
        queue_px(8'd255, 8'd10, 8'd5, 32'h0000_0000);
        drain();

        // oversized dimensions, bottom right corner of the largest buffer
        set_reg(gcab_pkg::REG_GRAY_MODE, 32'd1);
        set_reg(gcab_pkg::REG_BUFFER_WIDTH, 32'h0000_1FFF);
        set_reg(gcab_pkg::REG_BUFFER_HEIGHT, 32'd5000);
        set_reg(gcab_pkg::REG_ORIGIN_X, 32'd4000);
        set_reg(gcab_pkg::REG_ORIGIN_Y, 32'd4000);
        set_reg(gcab_pkg::REG_TEXT_COLOR, 32'h7F10_2030);
        queue_px(8'd255, 8'd95, 8'd95, 32'hAABB_CCDD);
        queue_px(8'd255, 8'd96, 8'd0, 32'hAABB_CCDD);
        queue_px(8'd200, 8'd0, 8'd0, 32'hAABB_CCDD);
        drain();

        // origin extremes
        set_reg(gcab_pkg::REG_ORIGIN_X, 32'hABCD_7FFF);
        set_reg(gcab_pkg::REG_ORIGIN_Y, 32'h0000_8000);
        queue_px(8'd255, 8'd0, 8'd0, 32'h0000_0000);
        drain();

        // unused indexes must not disturb anything
        set_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        set_reg(REG_SPARE_7, 32'h0000_0000);
        set_reg(gcab_pkg::REG_ORIGIN_X, 32'd0);
        set_reg(gcab_pkg::REG_ORIGIN_Y, 32'd0);
        set_reg(gcab_pkg::REG_BUFFER_WIDTH, 32'd4096);
        set_reg(gcab_pkg::REG_BUFFER_HEIGHT, 32'd4096);
        set_reg(gcab_pkg::REG_TEXT_COLOR, 32'h00FF_FFFF);
        queue_px(8'd255, 8'd1, 8'd1, 32'h0000_0000);
        drain();
        set_reg(gcab_pkg::REG_TEXT_COLOR, 32'hFFFF_FFFF);
        queue_px(8'd255, 8'd255, 8'd255, 32'h0000_0000);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick = $urandom_range(0, 9);
            dim = (pick == 0) ? 0 :
                  (pick == 1) ? $urandom_range(gcab_pkg::MAX_DIM + 1, 8191) :
                  (pick == 2) ? gcab_pkg::MAX_DIM : $urandom_range(1, 300);
            set_reg(gcab_pkg::REG_BUFFER_WIDTH, ($urandom & 32'hFFFF_E000) | dim);
            pick = $urandom_range(0, 9);
            dim = (pick == 0) ? 0 :
                  (pick == 1) ? $urandom_range(gcab_pkg::MAX_DIM + 1, 8191) :
                  (pick == 2) ? gcab_pkg::MAX_DIM : $urandom_range(1, 300);
            set_reg(gcab_pkg::REG_BUFFER_HEIGHT, ($urandom & 32'hFFFF_E000) | dim);
            pick = $urandom_range(0, 7);
            set_reg(gcab_pkg::REG_ORIGIN_X, {16'($urandom),
                    (pick == 0) ? 16'($urandom) : 16'($urandom_range(0, 320) - 64)});
            pick = $urandom_range(0, 7);
            set_reg(gcab_pkg::REG_ORIGIN_Y, {16'($urandom),
                    (pick == 0) ? 16'($urandom) : 16'($urandom_range(0, 320) - 64)});
            color = $urandom;
            pick = $urandom_range(0, 5);
            if (pick == 0)
                color[31:24] = 8'h00;
            else if (pick == 1)
                color[31:24] = 8'hFF;
            set_reg(gcab_pkg::REG_TEXT_COLOR, color);
            set_reg(gcab_pkg::REG_GRAY_MODE, $urandom);

            if (p == HOLD_PHASE)
            begin
                // sender runs flat out while the receiver holds off
                set_pace(1'b0, 1'b1);
                @(posedge clk);
                hold_req <= ~hold_req;
            end
            else
            begin
                set_pace($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                pick = $urandom_range(0, 7);
                cv  = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255);
                col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 63);
                row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 63);
                queue_px(8'(cv), 8'(col), 8'(row), $urandom);
            end
            drain();
        end

        if (err_count == 0 && px_write_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
